[rtl/core/sha256_hash_unit_macros.svh]
// ----------------------------------------------------------------------------
// SHA-256 hash unit assertion macros
// Assertion macros shared by the hash unit's RTL files.
// ----------------------------------------------------------------------------
`ifndef SHA256_HASH_UNIT_MACROS_SVH
`define SHA256_HASH_UNIT_MACROS_SVH
// An implication that must hold at every clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// An implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hash unit package
// Shared types, constants and round functions of the hash unit.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	// Command from the front part to the compression engine.
	typedef struct packed {
		logic [511:0] block;
		logic         final_blk;
	} blk_cmd_t;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [255:0] INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

[rtl/core/sha_front.sv]
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message words, packs bytes into blocks, counts the length and
// builds the padding blocks, handing each finished block to the queue.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha_pkg::in_word_t   in_data,
	output logic                cmd_valid,
	input  logic                cmd_stall,
	output sha_pkg::blk_cmd_t   cmd
);

	localparam logic [1:0] ST_IN   = 2'd0;
	localparam logic [1:0] ST_PAD2 = 2'd2;

	logic [1:0]   state_q;
	logic [60:0]  count_q;
	logic [511:0] buf_q;
	logic         cmd_valid_q;
	sha_pkg::blk_cmd_t cmd_q;

	logic         acc;
	logic [5:0]   pos;
	logic [511:0] buf_b;
	logic [511:0] pad_blk;
	logic [60:0]  count_n;
	logic [63:0]  bits;
	logic [5:0]   ppos;
	logic         cmd_load;

	// The output register is free when empty or being taken.
	logic out_free;
	assign out_free = !cmd_valid_q || !cmd_stall;
	assign in_stall = (state_q != ST_IN) || !out_free;
	assign acc      = in_valid && !in_stall;
	assign pos      = count_q[5:0];
	assign count_n  = in_data.has_byte ? count_q + 61'd1 : count_q;
	assign ppos     = count_n[5:0];
	assign bits     = {count_n, 3'b000};
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	// A block leaves on a full block, on the end of a message, or as the
	// trailing length block.
	assign cmd_load = (state_q == ST_IN)
		? (acc && (in_data.end_of_message || (in_data.has_byte && pos == 6'd63)))
		: (state_q == ST_PAD2 && out_free);

	// Buffer with the incoming byte placed; bytes past it are don't care.
	always_comb begin
		buf_b = buf_q;
		if (in_data.has_byte) begin
			buf_b[(7'd63 - {1'b0, pos}) * 8 +: 8] = in_data.data_byte;
		end
		pad_blk = buf_b;
		for (int i = 0; i < 64; i++) begin
			if (i[5:0] == ppos && !(in_data.has_byte && pos == 6'd63)) begin
				pad_blk[(63 - i) * 8 +: 8] = sha_pkg::PAD_BYTE;
			end else if (i[5:0] > ppos || (in_data.has_byte && pos == 6'd63)) begin
				pad_blk[(63 - i) * 8 +: 8] = 8'h00;
			end
		end
		if (in_data.has_byte && pos == 6'd63) begin
			pad_blk[511:504] = sha_pkg::PAD_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IN;
			count_q     <= '0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (cmd_load) begin
				cmd_valid_q <= 1'b1;
			end else if (cmd_valid_q && !cmd_stall) begin
				cmd_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IN: begin
					if (acc) begin
						if (in_data.end_of_message) begin
							// Full block just filled: send it, padding follows alone.
							if (in_data.has_byte && pos == 6'd63) begin
								cmd_q.block     <= buf_b;
								cmd_q.final_blk <= 1'b0;
								buf_q           <= pad_blk;
								count_q         <= count_n;
								state_q         <= ST_PAD2;
							end else if (ppos > 6'd55) begin
								cmd_q.block     <= pad_blk;
								cmd_q.final_blk <= 1'b0;
								buf_q           <= '0;
								count_q         <= count_n;
								state_q         <= ST_PAD2;
							end else begin
								cmd_q.block     <= {pad_blk[511:64], bits};
								cmd_q.final_blk <= 1'b1;
								count_q         <= '0;
							end
						end else begin
							buf_q   <= buf_b;
							count_q <= count_n;
							if (in_data.has_byte && pos == 6'd63) begin
								cmd_q.block     <= buf_b;
								cmd_q.final_blk <= 1'b0;
							end
						end
					end
				end
				ST_PAD2: begin
					if (out_free) begin
						cmd_q.block     <= {buf_q[511:64], count_q, 3'b000};
						cmd_q.final_blk <= 1'b1;
						count_q         <= '0;
						state_q         <= ST_IN;
					end
				end
				default: state_q <= ST_IN;
			endcase
		end
	end

endmodule

[rtl/core/sha_queue.sv]
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Two-entry queue of block commands between front end and engine.
// ----------------------------------------------------------------------------
module sha_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_stall,
	input  sha_pkg::blk_cmd_t   wr_data,
	output logic                rd_valid,
	input  logic                rd_stall,
	output sha_pkg::blk_cmd_t   rd_data
);

	sha_pkg::blk_cmd_t            mem_q [sha_pkg::QDEPTH];
	logic [sha_pkg::QPTR_W-1:0]   wptr_q;
	logic [sha_pkg::QPTR_W-1:0]   rptr_q;
	logic [sha_pkg::QPTR_W:0]     fill_q;
	logic                         wr;
	logic                         rd;

	assign wr_stall = (fill_q == (sha_pkg::QPTR_W + 1)'(sha_pkg::QDEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign wr       = wr_valid && !wr_stall;
	assign rd       = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			fill_q <= fill_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

[rtl/core/sha_engine.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Runs 64 rounds on each block, one a cycle, then emits the digest words
// after a final block and returns the chaining state to its start value.
// ----------------------------------------------------------------------------
`include "sha256_hash_unit_macros.svh"
module sha_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  sha_pkg::blk_cmd_t   cmd,
	output logic                out_valid,
	input  logic                stall,
	output sha_pkg::out_word_t  out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]   state_q;
	logic [5:0]   rnd_q;
	logic [255:0] h_q;
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic         fin_q;
	logic [2:0]   idx_q;
	logic         out_valid_q;
	sha_pkg::out_word_t out_q;

	logic [31:0] t1, t2, wnew;

	assign cmd_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign t1 = hh_q + sha_pkg::bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q))
		+ sha_pkg::round_k(rnd_q) + w_q[0];
	assign t2 = sha_pkg::bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	assign wnew = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= cmd.block[(15 - i) * 32 +: 32];
			end
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q} <= h_q;
			fin_q <= cmd.final_blk;
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnew;
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			h_q         <= sha_pkg::INIT_H;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q != ST_OUT && out_valid_q && !stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						rnd_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q <= {h_q[255:224] + a_q, h_q[223:192] + b_q, h_q[191:160] + c_q,
						h_q[159:128] + d_q, h_q[127:96] + e_q, h_q[95:64] + f_q,
						h_q[63:32] + g_q, h_q[31:0] + hh_q};
					idx_q   <= '0;
					state_q <= fin_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (!out_valid_q || !stall) begin
						out_q.digest_word <= h_q[(3'd7 - idx_q) * 32 +: 32];
						out_q.word_index  <= idx_q;
						out_q.last_word   <= (idx_q == 3'd7);
						out_valid_q       <= 1'b1;
						idx_q             <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							h_q     <= sha_pkg::INIT_H;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_run_rnd, clk, arst_n, state_q == ST_ADD, rnd_q == 6'd0, "round count off")
	`SHA_ASSERT_NEXT(a_idle_take, clk, arst_n, state_q == ST_IDLE && cmd_valid, state_q == ST_RUN, "no load")
	`SHA_ASSERT_IMP(a_last_idx, clk, arst_n, out_valid_q && out_q.last_word, out_q.word_index == 3'd7, "last word index")

endmodule

[rtl/core/sha256_hash_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 hash unit
// Byte-stream SHA-256 with a packing front end, block queue and round engine.
// ----------------------------------------------------------------------------
// Each input word carries one message byte or none, and a word with
// end_of_message set closes the message; the unit then returns the eight
// digest words, H0 first, and starts afresh for the next message. The round
// engine loads each 64-byte block, runs its 64 rounds and adds the result
// into the chaining state; the end of a message adds one or two blocks of
// padding, and the digest then leaves as eight output words. The two-entry
// queue lets the front end keep packing while the engine compresses the
// previous block.
module sha256_hash_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sha_pkg::out_word_t  out_data
);

	// Front end to queue.
	logic              f_valid, f_stall;
	sha_pkg::blk_cmd_t f_cmd;
	// Queue to engine.
	logic              e_valid, e_stall;
	sha_pkg::blk_cmd_t e_cmd;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd));

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_cmd),
		.rd_valid(e_valid), .rd_stall(e_stall), .rd_data(e_cmd));

	sha_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(e_valid), .cmd_stall(e_stall), .cmd(e_cmd),
		.out_valid(out_valid), .stall(out_stall), .out_data(out_data));

endmodule

[tb/sha256_hash_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash unit testbench
// Feeds byte-stream messages with random gaps and output stalls, predicts
// every digest word with a behavioral hash model and compares each word.
// ----------------------------------------------------------------------------
module sha256_hash_unit_test;

	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	sha_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_stall;
	sha_pkg::out_word_t out_data;

	sha256_hash_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Predictor state: running hash, packed block and length in bytes.
	logic [31:0] hash_h[8];
	logic [31:0] blk_w[16];
	logic [60:0] msg_len;

	// Digest words still owed by the unit, oldest first.
	sha_pkg::out_word_t digest_queue[$];

	// Message lengths around the padding boundary and the full block.
	int pad_lens[4] = '{55, 56, 63, 64};

	int  error_count = 0;
	int  words_sent = 0;
	int  digests_seen = 0;
	int  idle_cycles = 0;
	bit  stim_done = 0;
	bit  quiet_tail = 0;
	bit  long_hold = 0;

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] rk(int i);
		logic [31:0] k[64] = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[i];
	endfunction

	task automatic compress_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++) w[i] = blk_w[i];
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++) v[i] = hash_h[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk(i) + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_h[i] += v[i];
	endtask

	task automatic pack_byte(int pos, logic [7:0] b);
		int sh;
		sh = (3 - (pos & 3)) * 8;
		if ((pos & 3) == 0) begin
			blk_w[pos >> 2] = 32'(b) << sh;
		end else begin
			blk_w[pos >> 2] |= 32'(b) << sh;
		end
	endtask

	task automatic reset_hash();
		for (int i = 0; i < 8; i++) hash_h[i] = sha_pkg::INIT_H[255 - 32*i -: 32];
		msg_len = '0;
	endtask

	// Advances the predicted hash by one accepted word; queues the digest
	// words whenever the word closes a message.
	task automatic predict_digest(sha_pkg::in_word_t w);
		int pos;
		logic [63:0] bits;
		sha_pkg::out_word_t o;
		if (w.has_byte) begin
			pos = int'(msg_len[5:0]);
			pack_byte(pos, w.data_byte);
			msg_len++;
			if (pos == 63) compress_block();
		end
		if (w.end_of_message) begin
			pos = int'(msg_len[5:0]);
			pack_byte(pos, sha_pkg::PAD_BYTE);
			pos++;
			if (pos > 56) begin
				for (; pos < 64; pos++) pack_byte(pos, 8'h00);
				compress_block();
				pos = 0;
			end
			for (; pos < 56; pos++) pack_byte(pos, 8'h00);
			bits = {msg_len, 3'b000};
			blk_w[14] = bits[63:32];
			blk_w[15] = bits[31:0];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				o.digest_word = hash_h[i];
				o.word_index = 3'(i);
				o.last_word = (i == 7);
				digest_queue = {digest_queue, o};
			end
			reset_hash();
		end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// Receiver: checks each accepted digest word against the oldest one due.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (digest_queue.size() == 0) begin
				$display("%0t: unexpected digest word, expected none, actual %h",
					$time, out_data);
				error_count++;
			end else begin
				if (out_data !== digest_queue[0]) begin
					$display("%0t: digest mismatch, expected %h/%0d/%0d, actual %h/%0d/%0d",
						$time, digest_queue[0].digest_word, digest_queue[0].word_index,
						digest_queue[0].last_word, out_data.digest_word,
						out_data.word_index, out_data.last_word);
					error_count++;
				end
				if (out_data.last_word) digests_seen++;
				void'(digest_queue.pop_front());
			end
		end
	end

	// Receiver stall pattern, with one long hold-off so the queue backs up.
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1;
				repeat (400) @(negedge clk);
				long_hold = 0;
				out_stall <= 0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 0;
			end
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (arst_n && idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one word and waits for it to be taken; a random gap sometimes precedes it.
	task automatic send_word(sha_pkg::in_word_t w);
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_digest(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(int len, bit empty_end);
		sha_pkg::in_word_t w;
		for (int i = 0; i < len; i++) begin
			w.data_byte = 8'($urandom);
			w.has_byte = 1;
			w.end_of_message = (i == len - 1) && !empty_end;
			// Noise: occasional empty words inside the message.
			if ($urandom_range(0, 15) == 0) send_word('{8'($urandom), 1'b0, 1'b0});
			send_word(w);
		end
		if (empty_end || len == 0) send_word('{8'($urandom), 1'b0, 1'b1});
	endtask

	typedef struct {
		sha_pkg::in_word_t word;
		logic [31:0]       h0;
	} stim_row_t;

	// Directed rows. Where h0 is nonzero it is the known first digest word.
	stim_row_t dir_rows[] = '{
		'{'{8'h00, 1'b0, 1'b1}, 32'he3b0c442},   // empty message
		'{'{8'h61, 1'b1, 1'b0}, 32'h0},
		'{'{8'h62, 1'b1, 1'b0}, 32'h0},
		'{'{8'hff, 1'b0, 1'b0}, 32'h0},          // word with no byte is ignored
		'{'{8'h63, 1'b1, 1'b1}, 32'hba7816bf},   // "abc", end on last byte
		'{'{8'h00, 1'b1, 1'b1}, 32'h6e340b9c},   // single zero byte
		'{'{8'hff, 1'b1, 1'b0}, 32'h0},
		'{'{8'h00, 1'b0, 1'b1}, 32'h0}           // end without byte
	};

	initial begin
		in_valid = 0;
		in_data = '0;
		reset_hash();
		@(posedge arst_n);
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].h0 != 0) begin
				send_word(dir_rows[i].word);
				if (digest_queue[$-7].digest_word !== dir_rows[i].h0) begin
					$display("%0t: known digest, expected %h, actual predicted %h",
						$time, dir_rows[i].h0, digest_queue[$-7].digest_word);
					error_count++;
				end
			end else begin
				send_word(dir_rows[i].word);
			end
		end

		// Lengths around the padding boundary and a full block.
		foreach (pad_lens[i])
			send_message(pad_lens[i], 1'($urandom_range(0, 1)));

		// Sender pause: wait until every digest word is back.
		in_valid <= 0;
		wait (digest_queue.size() == 0);
		@(negedge clk);

		// Long receiver hold-off while short messages keep coming.
		long_hold = 1;
		for (int m = 0; m < 6; m++)
			send_message($urandom_range(0, 4), 1'($urandom_range(0, 1)));

		while (words_sent < 340) begin
			if (words_sent > 290) quiet_tail = 1;
			send_message($urandom_range(0, 20) == 0 ? $urandom_range(50, 80)
				: $urandom_range(0, 12), $urandom_range(0, 3) == 0);
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		wait (digest_queue.size() == 0);
		repeat (300) @(posedge clk);
		$display("Covered %0d input words and %0d digests, including padding edges,",
			words_sent, digests_seen);
		$display("empty messages, random gaps and a long output hold-off.");
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_front.sv
rtl/core/sha_queue.sv
rtl/core/sha_engine.sv
rtl/core/sha256_hash_unit.sv
tb/sha256_hash_unit_test.sv
